@@ sv/aecd_pkg.sv @@
// Shared types, constants and helpers for the alpha edge color dilation block.
`default_nettype none

package aecd_pkg;

    // Field and register widths
    localparam int CH_W          = 8;
    localparam int DIM_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = DIM_W;
    localparam int SUM_W         = CH_W + 3;
    localparam int CNT_W         = 4;
    localparam int RECIP_SHIFT   = 16;
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int MAX_WIDTH_DEF = 1024;

    // Register reset values
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(1024);
    localparam logic [CH_W-1:0]  ALPHA_REF_RST    = CH_W'(254);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_REF    = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
        logic            flush;
    } t_pixel_in;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            filled;
        logic            last_pixel;
        logic            any_filled;
    } t_pixel_out;

    // One stored pixel
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgba;

    // One line buffer word: same column of the two previous rows
    typedef struct packed {
        t_rgba upper;
        t_rgba lower;
    } t_lb_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DIV,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic shift;
        logic sum;
        logic mult;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic produce;
        logic out_free;
    } t_dp_status;

    // Reciprocal ceil(2^16 / n) for n in 1..8; exact floor division for sums below 2048
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = RECIP_W'(65536);
            4'd2:    m = RECIP_W'(32768);
            4'd3:    m = RECIP_W'(21846);
            4'd4:    m = RECIP_W'(16384);
            4'd5:    m = RECIP_W'(13108);
            4'd6:    m = RECIP_W'(10923);
            4'd7:    m = RECIP_W'(9363);
            4'd8:    m = RECIP_W'(8192);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ sv/alpha_edge_color_dilation_core.sv @@
// Top level of the alpha edge color dilation block: sequencer plus datapath.
// Sequence: after its input beat is accepted, a result beat passes through the line buffer
//   read, window shift, neighbor sum and multiply before it is loaded into the output register.
// Flow: a new beat is accepted only after the previous one is emitted or dropped; the
//   sequencer takes each beat through the single line buffer port and the sum/divide stages.
// Reset: synchronous active low; clears position, fill flag, output valid and
//   restores the registers; the line buffer is not cleared and needs no clearing pass.
`default_nettype none

module alpha_edge_color_dilation_core #(
    parameter int MAX_WIDTH = aecd_pkg::MAX_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [aecd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [aecd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  aecd_pkg::t_pixel_in              i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output aecd_pkg::t_pixel_out             o_out_data
);
    import aecd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    aecd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    aecd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

@@ sv/aecd_ctrl.sv @@
// Sequencer that walks each pixel beat through read, window update, sum, divide and emit.
`default_nettype none

module aecd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output aecd_pkg::t_dp_cmd    o_cmd,
    input  aecd_pkg::t_dp_status i_status
);
    import aecd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.shift = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.mult = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // Drop lead-in beats; otherwise wait for room in the output register
                if (!i_status.produce) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/aecd_datapath.sv @@
// Line buffer, 3x3 window, neighbor mean, registers and output stage of the dilation block.
`default_nettype none

module aecd_datapath #(
    parameter int MAX_WIDTH = aecd_pkg::MAX_WIDTH_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [aecd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [aecd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  aecd_pkg::t_pixel_in                   i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output aecd_pkg::t_pixel_out                  o_out_data,
    input  aecd_pkg::t_dp_cmd                     i_cmd,
    output aecd_pkg::t_dp_status                  o_status
);
    import aecd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WW_W   = $clog2(MAX_WIDTH + 1);
    localparam int CW     = (WW_W > DIM_W) ? WW_W : DIM_W;
    localparam int ROW_W  = DIM_W + 1;
    localparam int PROD_W = SUM_W + RECIP_W;

    // Configuration registers
    logic [DIM_W-1:0] r_cfg_width;
    logic [DIM_W-1:0] r_cfg_height;
    logic [CH_W-1:0]  r_alpha_ref;
    logic             geom_write;

    // Position of the incoming beat, flush positions included
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;

    // Line buffer
    t_lb_word r_lb_mem [MAX_WIDTH];
    t_lb_word r_lb_rd;
    t_rgba    r_pix;

    // Window: [column][row], column 0 left, row 0 top
    t_rgba r_win [3][3];

    // Geometry flags of the current center
    logic r_produce, r_last, r_left_ok, r_right_ok, r_top_ok, r_bot_ok;

    // Sum stage
    logic [SUM_W-1:0] r_sum_red, r_sum_grn, r_sum_blu;
    logic [CNT_W-1:0] r_cnt;
    logic             r_fill;
    t_rgba            r_center;

    // Multiply stage
    logic [PROD_W-1:0] r_prod_red, r_prod_grn, r_prod_blu;

    logic       r_fill_seen;
    logic       r_out_valid;
    t_pixel_out r_out_data;

    // Effective geometry
    logic [CW-1:0]    w_ext, w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             col_zero, col_wrap;

    assign w_ext = CW'(r_cfg_width);
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CW'(1);
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff = (r_cfg_height == '0) ? ROW_W'(1) : ROW_W'(r_cfg_height);
    end

    assign col_zero   = (r_col == '0);
    assign col_wrap   = (CW'(r_col) + CW'(1)) >= w_eff;
    assign geom_write = i_cfg_we &&
                        (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= FRAME_WIDTH_RST;
            r_cfg_height <= FRAME_HEIGHT_RST;
            r_alpha_ref  <= ALPHA_REF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_ALPHA_REF:    r_alpha_ref  <= i_cfg_data[CH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Advance position; restart on frame end or geometry write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_write) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.shift) begin
            if (r_row == h_eff + ROW_W'(1) && col_zero) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_wrap) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    // Line buffer read on accept, write back on shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lb_rd <= r_lb_mem[r_col];
            r_pix   <= '{alpha: i_in_data.in_alpha, blue: i_in_data.in_blue,
                         green: i_in_data.in_green, red: i_in_data.in_red};
        end
        if (i_cmd.shift) begin
            r_lb_mem[r_col] <= '{upper: r_lb_rd.lower, lower: r_pix};
        end
    end

    // Shift window and capture center geometry
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= r_lb_rd.upper;
            r_win[2][1] <= r_lb_rd.lower;
            r_win[2][2] <= r_pix;
            r_produce   <= (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && !col_zero);
            r_last      <= (r_row == h_eff + ROW_W'(1)) && col_zero;
            r_left_ok   <= col_zero ? (w_eff != CW'(1)) : (r_col >= ADDR_W'(2));
            r_right_ok  <= !col_zero;
            r_top_ok    <= col_zero ? (r_row >= ROW_W'(3)) : (r_row >= ROW_W'(2));
            r_bot_ok    <= col_zero ? (r_row <= h_eff) : (r_row < h_eff);
        end
    end

    // Sum qualifying neighbors
    logic [SUM_W-1:0] s_red, s_grn, s_blu;
    logic [CNT_W-1:0] s_cnt;
    logic             col_ok, row_ok;

    always_comb begin
        s_red  = '0;
        s_grn  = '0;
        s_blu  = '0;
        s_cnt  = '0;
        col_ok = 1'b0;
        row_ok = 1'b0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                col_ok = (c == 0) ? r_left_ok : ((c == 2) ? r_right_ok : 1'b1);
                row_ok = (r == 0) ? r_top_ok  : ((r == 2) ? r_bot_ok   : 1'b1);
                if (!(c == 1 && r == 1) && col_ok && row_ok &&
                    (r_win[c][r].alpha > r_alpha_ref)) begin
                    s_red = s_red + SUM_W'(r_win[c][r].red);
                    s_grn = s_grn + SUM_W'(r_win[c][r].green);
                    s_blu = s_blu + SUM_W'(r_win[c][r].blue);
                    s_cnt = s_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum_red <= s_red;
            r_sum_grn <= s_grn;
            r_sum_blu <= s_blu;
            r_cnt     <= s_cnt;
            r_center  <= r_win[1][1];
            r_fill    <= (r_win[1][1].alpha == '0) && (s_cnt != '0);
        end
    end

    // Divide by count through reciprocal multiply
    logic [RECIP_W-1:0] recip_cnt;
    assign recip_cnt = recip(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod_red <= PROD_W'(r_sum_red) * PROD_W'(recip_cnt);
            r_prod_grn <= PROD_W'(r_sum_grn) * PROD_W'(recip_cnt);
            r_prod_blu <= PROD_W'(r_sum_blu) * PROD_W'(recip_cnt);
        end
    end

    // Track fills across the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_write) begin
            r_fill_seen <= 1'b0;
        end else if (i_cmd.load_out) begin
            if (r_last) begin
                r_fill_seen <= 1'b0;
            end else if (r_fill) begin
                r_fill_seen <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.out_red    <= r_fill ? r_prod_red[RECIP_SHIFT+CH_W-1:RECIP_SHIFT]
                                            : r_center.red;
            r_out_data.out_green  <= r_fill ? r_prod_grn[RECIP_SHIFT+CH_W-1:RECIP_SHIFT]
                                            : r_center.green;
            r_out_data.out_blue   <= r_fill ? r_prod_blu[RECIP_SHIFT+CH_W-1:RECIP_SHIFT]
                                            : r_center.blue;
            r_out_data.out_alpha  <= r_fill ? r_alpha_ref : r_center.alpha;
            r_out_data.filled     <= r_fill;
            r_out_data.last_pixel <= r_last;
            r_out_data.any_filled <= r_last && (r_fill_seen || r_fill);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.produce  = r_produce;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Checks
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.accept, i_cmd.shift, i_cmd.sum, i_cmd.mult, i_cmd.load_out}))
        else $error("datapath commands overlap");

    a_load_needs_produce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (r_produce && (!r_out_valid || i_out_ready)))
        else $error("result loaded for a lead-in beat or over a pending beat");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < w_eff)
        else $error("column position beyond frame width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_eff + ROW_W'(1))
        else $error("row position beyond flush row");

    a_any_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.any_filled) |-> r_out_data.last_pixel)
        else $error("frame fill flag raised off the last pixel");

endmodule

`default_nettype wire

@@ tb/sv/aecd_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the alpha edge color dilation block: predicts each output beat and compares.
module aecd_result_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [aecd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [aecd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                               i_in_valid,
    input  wire                               i_in_ready,
    input  aecd_pkg::t_pixel_in               i_in_data,
    input  wire                               i_out_valid,
    input  wire                               i_out_ready,
    input  aecd_pkg::t_pixel_out              i_out_data,
    output int unsigned                       o_mismatches,
    output int unsigned                       o_pending,
    output int unsigned                       o_results,
    output int unsigned                       o_fills,
    output int unsigned                       o_frames
);
    import aecd_pkg::*;

    localparam int HIST_DEPTH   = 2 * MAX_WIDTH_DEF + 4;
    localparam int REPORT_LIMIT = 10;

    // Shadow registers and frame position
    logic [DIM_W-1:0] frame_cols;
    logic [DIM_W-1:0] frame_rows;
    logic [CH_W-1:0]  alpha_level;
    int unsigned      col_pos;
    int unsigned      row_pos;
    bit               frame_fill_seen;

    // Raw pixel history, indexed by frame position
    t_rgba            pixel_history [HIST_DEPTH];
    t_pixel_out       expected_pixels [$];

    function automatic void restart_frame();
        col_pos         = 0;
        row_pos         = 0;
        frame_fill_seen = 1'b0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FRAME_WIDTH) begin
            frame_cols = data;
            restart_frame();
        end else if (idx == CFG_FRAME_HEIGHT) begin
            frame_rows = data;
            restart_frame();
        end else if (idx == CFG_ALPHA_REF) begin
            alpha_level = data[CH_W-1:0];
        end
    endfunction

    // Store the incoming pixel and produce the pixel one row plus one behind it
    function automatic void predict_dilation(input t_pixel_in beat, output bit has_res,
                                             output t_pixel_out res);
        int unsigned w, h, npix, k, p, cx, cy, cnt, sum_r, sum_g, sum_b, idx;
        int          nx, ny, dx, dy;
        t_rgba       centre, nb;
        bit          last;
        w = (frame_cols == 0) ? 1 : ((frame_cols > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : frame_cols);
        h = (frame_rows == 0) ? 1 : frame_rows;
        npix = w * h;
        k = row_pos * w + col_pos;
        has_res = 1'b0;
        res = '0;
        if (k < npix) begin
            pixel_history[k % HIST_DEPTH] = '{alpha: beat.in_alpha, blue: beat.in_blue,
                                              green: beat.in_green, red: beat.in_red};
        end
        if (k >= w + 1) begin
            p = k - w - 1;
            cx = p % w;
            cy = p / w;
            centre = pixel_history[p % HIST_DEPTH];
            last = (p == npix - 1);
            res.out_red   = centre.red;
            res.out_green = centre.green;
            res.out_blue  = centre.blue;
            res.out_alpha = centre.alpha;
            if (centre.alpha == 0) begin
                cnt = 0;
                sum_r = 0;
                sum_g = 0;
                sum_b = 0;
                // Average the opaque in-image neighbors
                for (dy = -1; dy <= 1; dy++) begin
                    for (dx = -1; dx <= 1; dx++) begin
                        nx = int'(cx) + dx;
                        ny = int'(cy) + dy;
                        if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 &&
                            nx < int'(w) && ny < int'(h)) begin
                            idx = (int'(ny) * w + int'(nx)) % HIST_DEPTH;
                            nb = pixel_history[idx];
                            if (nb.alpha > alpha_level) begin
                                sum_r += nb.red;
                                sum_g += nb.green;
                                sum_b += nb.blue;
                                cnt++;
                            end
                        end
                    end
                end
                if (cnt != 0) begin
                    res.out_red     = CH_W'(sum_r / cnt);
                    res.out_green   = CH_W'(sum_g / cnt);
                    res.out_blue    = CH_W'(sum_b / cnt);
                    res.out_alpha   = alpha_level;
                    res.filled      = 1'b1;
                    frame_fill_seen = 1'b1;
                end
            end
            res.last_pixel = last;
            res.any_filled = last && frame_fill_seen;
            has_res = 1'b1;
        end
        // Advance the position, or wrap to a new frame after the last flush slot
        if (k >= npix + w) begin
            restart_frame();
        end else begin
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end
    endfunction

    function automatic void flag_failure(input string msg);
        if (o_mismatches < REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
        o_mismatches++;
    endfunction

    // Watch configuration, input and output beats
    always @(posedge i_clk) begin : watch
        bit         has_res;
        t_pixel_out want;
        if (!i_rst_n) begin
            frame_cols   = FRAME_WIDTH_RST;
            frame_rows   = FRAME_HEIGHT_RST;
            alpha_level  = ALPHA_REF_RST;
            restart_frame();
            expected_pixels.delete();
            o_mismatches = 0;
            o_results    = 0;
            o_fills      = 0;
            o_frames     = 0;
        end else begin
            if (i_cfg_we) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict_dilation(i_in_data, has_res, want);
                if (has_res) begin
                    expected_pixels.insert(expected_pixels.size(), want);
                end
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (i_out_data.filled) o_fills++;
                if (i_out_data.last_pixel) o_frames++;
                if (expected_pixels.size() == 0) begin
                    flag_failure("output beat with no result outstanding");
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_data.out_red    !== want.out_red    ||
                        i_out_data.out_green  !== want.out_green  ||
                        i_out_data.out_blue   !== want.out_blue   ||
                        i_out_data.out_alpha  !== want.out_alpha  ||
                        i_out_data.filled     !== want.filled     ||
                        i_out_data.last_pixel !== want.last_pixel ||
                        i_out_data.any_filled !== want.any_filled) begin
                        flag_failure($sformatf(
                            {"pixel mismatch: expected rgba %0d %0d %0d %0d fill %0b last %0b",
                             " any %0b, got rgba %0d %0d %0d %0d fill %0b last %0b any %0b"},
                            want.out_red, want.out_green, want.out_blue, want.out_alpha,
                            want.filled, want.last_pixel, want.any_filled,
                            i_out_data.out_red, i_out_data.out_green, i_out_data.out_blue,
                            i_out_data.out_alpha, i_out_data.filled, i_out_data.last_pixel,
                            i_out_data.any_filled));
                    end
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the alpha edge color dilation block: clock, reset, stimulus and verdict.
module tb_top;
    import aecd_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int QUIET_AFTER    = 1400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_pixel_in             in_data   = '0;
    logic                  out_ready = 1'b0;
    wire                   in_ready;
    wire                   out_valid;
    t_pixel_out            out_data;

    int unsigned mismatches, pending, results, fills, frames;

    // Stimulus control
    bit               quiet    = 1'b0;
    bit               gap_free = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      items_sent;
    logic [DIM_W-1:0] shadow_w   = FRAME_WIDTH_RST;
    logic [DIM_W-1:0] shadow_h   = FRAME_HEIGHT_RST;
    logic [CH_W-1:0]  shadow_ref = ALPHA_REF_RST;

    alpha_edge_color_dilation_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    aecd_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_fills      (fills),
        .o_frames     (frames)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offer one beat, with an optional idle burst first, and hold it until accepted
    task automatic send_beat(input t_pixel_in beat);
        if (!quiet && !gap_free && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Wait for every outstanding result plus the block's internal latency
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)  shadow_w = data;
        if (idx == CFG_FRAME_HEIGHT) shadow_h = data;
        if (idx == CFG_ALPHA_REF)    shadow_ref = data[CH_W-1:0];
    endtask

    function automatic t_pixel_in make_beat(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] a,
                                            input logic f);
        return '{in_red: r, in_green: g, in_blue: b, in_alpha: a, flush: f};
    endfunction

    function automatic logic [CH_W-1:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly holes and opaque pixels, some right at the reference level
    function automatic t_pixel_in random_beat(input bit pixel_slot);
        t_pixel_in beat;
        beat.in_red   = random_channel();
        beat.in_green = random_channel();
        beat.in_blue  = random_channel();
        case ($urandom_range(0, 9))
            0, 1, 2: beat.in_alpha = '0;
            3, 4, 5: beat.in_alpha = '1;
            6:       beat.in_alpha = shadow_ref;
            7:       beat.in_alpha = shadow_ref + 1'b1;
            default: beat.in_alpha = CH_W'($urandom_range(0, 255));
        endcase
        beat.flush = !pixel_slot;
        if ($urandom_range(0, 15) == 0) beat.flush = ~beat.flush;
        return beat;
    endfunction

    function automatic int unsigned eff_width();
        if (shadow_w == 0) return 1;
        if (shadow_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return shadow_w;
    endfunction

    // Send one frame plus its flush slots, or stop early after cut_at beats
    task automatic run_frame(input int unsigned cut_at);
        int unsigned w, npix, total;
        w = eff_width();
        npix = w * ((shadow_h == 0) ? 1 : shadow_h);
        total = npix + w + 1;
        for (int unsigned i = 0; i < total && i < cut_at; i++) begin
            send_beat(random_beat(i < npix));
        end
    endtask

    // Output side: random stalls, and one long hold-off on request
    initial begin : sink
        int unsigned n;
        bit          hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n - 1) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stop the run when no beat moves for too long
    initial begin : watchdog
        int unsigned still_cycles;
        still_cycles = 0;
        while (still_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) still_cycles = 0;
            else still_cycles++;
        end
        $display("alpha_edge_color_dilation_core verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned random_items, start_count, total, cut;
        bit          aborted;
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x2 frame: holes with full-range neighbors, one neighbor at the reference
        write_reg(CFG_FRAME_WIDTH, 11'd3);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        write_reg(CFG_ALPHA_REF, 11'd254);
        send_beat(make_beat(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
        send_beat(make_beat(8'd9, 8'd9, 8'd9, 8'd0, 1'b0));
        send_beat(make_beat(8'd255, 8'd0, 8'd255, 8'd255, 1'b0));
        send_beat(make_beat(8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
        send_beat(make_beat(8'd77, 8'd77, 8'd77, 8'd0, 1'b0));
        send_beat(make_beat(8'd1, 8'd2, 8'd3, 8'd254, 1'b0));
        repeat (4) send_beat(make_beat(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));

        // Zero geometry acts as 1x1; flush bits inverted; unused index ignored
        write_reg(CFG_FRAME_WIDTH, 11'd0);
        write_reg(CFG_FRAME_HEIGHT, 11'd0);
        write_reg(CFG_UNUSED, 11'h7FF);
        send_beat(make_beat(8'd200, 8'd100, 8'd50, 8'd0, 1'b1));
        send_beat(make_beat(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
        send_beat(make_beat(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));

        // Reference at its top: no neighbor can qualify
        write_reg(CFG_FRAME_WIDTH, 11'd2);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        write_reg(CFG_ALPHA_REF, 11'd255);
        send_beat(make_beat(8'd10, 8'd20, 8'd30, 8'd0, 1'b0));
        send_beat(make_beat(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
        send_beat(make_beat(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_beat(make_beat(8'd40, 8'd50, 8'd60, 8'd255, 1'b0));
        repeat (3) send_beat(make_beat(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));

        // Reference zero, tallest height, then restart the frame midway
        write_reg(CFG_ALPHA_REF, 11'd0);
        write_reg(CFG_FRAME_HEIGHT, 11'h7FF);
        send_beat(make_beat(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_beat(make_beat(8'd100, 8'd1, 8'd1, 8'd1, 1'b0));
        send_beat(make_beat(8'd3, 8'd5, 8'd7, 8'd0, 1'b0));
        write_reg(CFG_FRAME_HEIGHT, 11'd2);

        // Random frames, mostly small; one narrow tall frame under a long output hold-off
        random_items = 0;
        aborted = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            start_count = items_sent;
            if (aborted || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_FRAME_WIDTH, 11'd0);
                    1:       write_reg(CFG_FRAME_WIDTH, 11'd1);
                    default: write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(2, 10)));
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
                end
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_ALPHA_REF, 11'd0);
                    1:       write_reg(CFG_ALPHA_REF, 11'd255);
                    2:       write_reg(CFG_ALPHA_REF, CFG_DATA_W'($urandom_range(0, 2047)));
                    default: ;
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));
                end
            end
            gap_free = ($urandom_range(0, 3) == 0);
            total = eff_width() * ((shadow_h == 0) ? 1 : shadow_h) + eff_width() + 1;
            aborted = (total > 1) && ($urandom_range(0, 9) == 0);
            cut = aborted ? $urandom_range(1, total - 1) : total;
            run_frame(cut);
            random_items += items_sent - start_count;

            // Results start after a short lead-in, so the hold-off stalls the input
            if (random_items >= RANDOM_ITEMS / 4 && !hold_req) begin
                write_reg(CFG_FRAME_WIDTH, 11'd4);
                write_reg(CFG_FRAME_HEIGHT, 11'd20);
                write_reg(CFG_ALPHA_REF, 11'd128);
                gap_free = 1'b0;
                start_count = items_sent;
                hold_req <= 1'b1;
                run_frame(4 * 20 + 4 + 1);
                random_items += items_sent - start_count;
                aborted = 1'b1;
            end
            if (random_items >= QUIET_AFTER) quiet = 1'b1;
        end

        wait_drained();
        $display("Sent %0d beats over directed and random frames; checked %0d result beats,",
                 items_sent, results);
        $display("%0d of them filled, %0d frames completed, with stalls and one long hold-off.",
                 fills, frames);
        if (mismatches == 0) begin
            $display("alpha_edge_color_dilation_core verification clean");
        end else begin
            $display("alpha_edge_color_dilation_core verification failed");
        end
        $finish;
    end

endmodule
